### hw/rtl/i2ctpm_pkg.sv
package i2ctpm_pkg;

   localparam int PACKET_BYTES_DEFAULT = 64;

   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   localparam logic [2:0] FUNC_ADDR_MATCH = 3'd0;
   localparam logic [2:0] FUNC_WRITE_BYTE = 3'd1;
   localparam logic [2:0] FUNC_READ_REQ   = 3'd2;
   localparam logic [2:0] FUNC_STOP       = 3'd3;
   localparam logic [2:0] FUNC_HOST_LOAD  = 3'd4;
   localparam logic [2:0] FUNC_HOST_COMMIT = 3'd5;

   localparam logic [1:0] KIND_STATUS = 2'd0;
   localparam logic [1:0] KIND_READ   = 2'd1;
   localparam logic [1:0] KIND_RX     = 2'd2;

   localparam logic [2:0] OP_STATUS   = 3'd0;
   localparam logic [2:0] OP_RX_WRITE = 3'd1;
   localparam logic [2:0] OP_TX_WRITE = 3'd2;
   localparam logic [2:0] OP_TX_READ  = 3'd3;
   localparam logic [2:0] OP_DUMP     = 3'd4;

   typedef struct packed {
      logic accepted;
      logic tx_done;
      logic tx_pending;
      logic rx_overrun;
      logic rx_short;
      logic tx_overrun;
      logic tx_short;
   } status_type;

   typedef struct packed {
      logic [2:0] op;
      logic [7:0] data;
      logic       zero;
      status_type status;
   } cmd_type;

   function automatic int idx_width(input int n);
      return (n > 1) ? $clog2(n) : 1;
   endfunction

   function automatic int pos_width(input int n);
      return $clog2(n + 1);
   endfunction

endpackage

### hw/rtl/i2c_target_packet_mailbox_top.sv
// Channel   Ports                                        Handshake
// request   req_func, req_read_dir, req_data_byte        taken when start && !busy
// response  rsp_kind, rsp_out_byte, rsp_last, rsp_*      one cycle, marked by rsp_strobe
//
// One event is taken per cycle while the four-entry command queue has room.
// Each event gives one word, registered by the back end when it pops the event.
// A stop with a full receive packet gives PACKET_BYTES words on consecutive
// cycles, and the back end pops no command meanwhile, so busy rises when the
// queue fills. Reset is synchronous and clears all control state; the
// packet stores are not cleared. The receiver cannot stall the result words.
module i2c_target_packet_mailbox_top
   import i2ctpm_pkg::*;
#(
   parameter int PACKET_BYTES = PACKET_BYTES_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   output logic       busy,
   input  logic [2:0] req_func,
   input  logic       req_read_dir,
   input  logic [7:0] req_data_byte,
   output logic       rsp_strobe,
   output logic [1:0] rsp_kind,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_last,
   output logic       rsp_accepted,
   output logic       rsp_tx_done,
   output logic       rsp_tx_pending,
   output logic       rsp_rx_overrun,
   output logic       rsp_rx_short,
   output logic       rsp_tx_overrun,
   output logic       rsp_tx_short
);

   localparam int IDX_W  = idx_width(PACKET_BYTES);
   localparam int CMD_W  = $bits(cmd_type);
   localparam int DATA_W = IDX_W + CMD_W;

   logic              push, pop, full, empty;
   cmd_type           f_cmd, b_cmd;
   logic [IDX_W-1:0]  f_addr, b_addr;
   logic [DATA_W-1:0] q_wr, q_rd;
   status_type        status;

   assign busy = full;

   i2ctpm_front #(
      .PACKET_BYTES(PACKET_BYTES)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .full      (full),
      .func      (req_func),
      .read_dir  (req_read_dir),
      .data_byte (req_data_byte),
      .push      (push),
      .cmd       (f_cmd),
      .addr      (f_addr)
   );

   assign q_wr = {f_addr, f_cmd};

   i2ctpm_cmd_queue #(
      .DATA_W(DATA_W)
   ) u_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (push),
      .wr_data (q_wr),
      .pop     (pop),
      .rd_data (q_rd),
      .full    (full),
      .empty   (empty)
   );

   assign b_addr = q_rd[DATA_W-1 -: IDX_W];
   assign b_cmd  = cmd_type'(q_rd[CMD_W-1:0]);

   i2ctpm_back #(
      .PACKET_BYTES(PACKET_BYTES)
   ) u_back (
      .clock        (clock),
      .reset        (reset),
      .empty        (empty),
      .cmd          (b_cmd),
      .addr         (b_addr),
      .pop          (pop),
      .rsp_strobe   (rsp_strobe),
      .rsp_kind     (rsp_kind),
      .rsp_out_byte (rsp_out_byte),
      .rsp_last     (rsp_last),
      .rsp_status   (status)
   );

   assign rsp_accepted   = status.accepted;
   assign rsp_tx_done    = status.tx_done;
   assign rsp_tx_pending = status.tx_pending;
   assign rsp_rx_overrun = status.rx_overrun;
   assign rsp_rx_short   = status.rx_short;
   assign rsp_tx_overrun = status.tx_overrun;
   assign rsp_tx_short   = status.tx_short;

endmodule

### hw/rtl/i2ctpm_front.sv
module i2ctpm_front
   import i2ctpm_pkg::*;
#(
   parameter int PACKET_BYTES = PACKET_BYTES_DEFAULT,
   localparam int IDX_W = idx_width(PACKET_BYTES),
   localparam int POS_W = pos_width(PACKET_BYTES)
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic             full,
   input  logic [2:0]       func,
   input  logic             read_dir,
   input  logic [7:0]       data_byte,
   output logic             push,
   output cmd_type          cmd,
   output logic [IDX_W-1:0] addr
);

   localparam logic [POS_W-1:0] FULL_POS = POS_W'(PACKET_BYTES);

   logic [POS_W-1:0] send_len_ff, send_len_in;
   logic [POS_W-1:0] load_pos_ff, load_pos_in;
   logic [POS_W-1:0] send_pos_ff, send_pos_in;
   logic [POS_W-1:0] recv_pos_ff, recv_pos_in;
   logic             pending_ff, pending_in;
   logic             sending_ff, sending_in;
   logic [3:0]       flags_ff, flags_in;
   logic             accepted;
   logic             done;

   assign push = start & ~full;

   always_comb begin
      send_len_in = send_len_ff;
      load_pos_in = load_pos_ff;
      send_pos_in = send_pos_ff;
      recv_pos_in = recv_pos_ff;
      pending_in  = pending_ff;
      sending_in  = sending_ff;
      flags_in    = flags_ff;
      accepted    = 1'b0;
      done        = 1'b0;
      cmd.op      = OP_STATUS;
      cmd.data    = data_byte;
      cmd.zero    = 1'b1;
      addr        = '0;
      case (func)
         FUNC_ADDR_MATCH: begin
            send_pos_in = '0;
            recv_pos_in = '0;
            sending_in  = read_dir & pending_ff;
         end
         FUNC_WRITE_BYTE: begin
            if (recv_pos_ff < FULL_POS) begin
               cmd.op      = OP_RX_WRITE;
               addr        = recv_pos_ff[IDX_W-1:0];
               recv_pos_in = recv_pos_ff + 1'b1;
            end else begin
               flags_in[0] = 1'b1;
            end
         end
         FUNC_READ_REQ: begin
            cmd.op = OP_TX_READ;
            if (sending_ff && (send_pos_ff < FULL_POS)) begin
               cmd.zero    = ~(send_pos_ff < send_len_ff);
               addr        = send_pos_ff[IDX_W-1:0];
               send_pos_in = send_pos_ff + 1'b1;
            end else begin
               flags_in[2] = 1'b1;
            end
         end
         FUNC_STOP: begin
            if ((recv_pos_ff != FULL_POS) && (recv_pos_ff != '0)) begin
               flags_in[1] = 1'b1;
            end
            sending_in = 1'b0;
            if (send_pos_ff == FULL_POS) begin
               pending_in = 1'b0;
               done       = 1'b1;
            end else if (send_pos_ff != '0) begin
               flags_in[3] = 1'b1;
            end
            if (recv_pos_ff == FULL_POS) begin
               cmd.op = OP_DUMP;
            end
         end
         FUNC_HOST_LOAD: begin
            if (!pending_ff && (load_pos_ff < FULL_POS)) begin
               cmd.op      = OP_TX_WRITE;
               addr        = load_pos_ff[IDX_W-1:0];
               load_pos_in = load_pos_ff + 1'b1;
               accepted    = 1'b1;
            end
         end
         FUNC_HOST_COMMIT: begin
            if (!pending_ff) begin
               send_len_in = load_pos_ff;
               load_pos_in = '0;
               pending_in  = 1'b1;
               accepted    = 1'b1;
            end
         end
         default: begin
         end
      endcase
      cmd.status.accepted   = accepted;
      cmd.status.tx_done    = done;
      cmd.status.tx_pending = pending_in;
      cmd.status.rx_overrun = flags_in[0];
      cmd.status.rx_short   = flags_in[1];
      cmd.status.tx_overrun = flags_in[2];
      cmd.status.tx_short   = flags_in[3];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         send_len_ff <= '0;
         load_pos_ff <= '0;
         send_pos_ff <= '0;
         recv_pos_ff <= '0;
         pending_ff  <= 1'b0;
         sending_ff  <= 1'b0;
         flags_ff    <= '0;
      end else if (push) begin
         send_len_ff <= send_len_in;
         load_pos_ff <= load_pos_in;
         send_pos_ff <= send_pos_in;
         recv_pos_ff <= recv_pos_in;
         pending_ff  <= pending_in;
         sending_ff  <= sending_in;
         flags_ff    <= flags_in;
      end
   end

`ifndef SYNTH
   a_sending_needs_pending: assert property (@(posedge clock) disable iff (reset)
      sending_ff |-> pending_ff)
      else $error("Transfer marked as sending without a pending packet.");

   a_positions_bounded: assert property (@(posedge clock) disable iff (reset)
      (load_pos_ff <= FULL_POS) && (send_pos_ff <= FULL_POS) && (recv_pos_ff <= FULL_POS))
      else $error("A buffer position ran past the packet size.");
`endif

endmodule

### hw/rtl/i2ctpm_cmd_queue.sv
module i2ctpm_cmd_queue
   import i2ctpm_pkg::*;
#(
   parameter int DATA_W = 8
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  logic [DATA_W-1:0] wr_data,
   input  logic              pop,
   output logic [DATA_W-1:0] rd_data,
   output logic              full,
   output logic              empty
);

   localparam logic [QPTR_W-1:0] LAST_PTR = QPTR_W'(QUEUE_DEPTH - 1);

   logic [DATA_W-1:0] q_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] count_ff, count_in;

   assign full    = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign empty   = (count_ff == '0);
   assign rd_data = q_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

### hw/rtl/i2ctpm_back.sv
module i2ctpm_back
   import i2ctpm_pkg::*;
#(
   parameter int PACKET_BYTES = PACKET_BYTES_DEFAULT,
   localparam int IDX_W = idx_width(PACKET_BYTES)
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             empty,
   input  cmd_type          cmd,
   input  logic [IDX_W-1:0] addr,
   output logic             pop,
   output logic             rsp_strobe,
   output logic [1:0]       rsp_kind,
   output logic [7:0]       rsp_out_byte,
   output logic             rsp_last,
   output status_type       rsp_status
);

   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(PACKET_BYTES - 1);

   logic [7:0]       tx_mem [PACKET_BYTES];
   logic [7:0]       rx_mem [PACKET_BYTES];
   logic [7:0]       tx_rd_ff;
   logic [7:0]       rx_rd_ff;
   logic             tx_we, rx_we, tx_re, rx_re;
   logic [IDX_W-1:0] rx_raddr;

   logic             strobe_ff, strobe_in;
   logic [1:0]       kind_ff, kind_in;
   logic             last_ff, last_in;
   logic             zero_ff, zero_in;
   logic             from_rx_ff, from_rx_in;
   status_type       status_ff, status_in;
   logic             dumping_ff, dumping_in;
   logic [IDX_W-1:0] dump_idx_ff, dump_idx_in;
   status_type       dump_status_ff, dump_status_in;

   always_comb begin
      pop            = ~empty & ~dumping_ff;
      tx_we          = 1'b0;
      rx_we          = 1'b0;
      tx_re          = 1'b0;
      rx_re          = 1'b0;
      rx_raddr       = dump_idx_ff;
      strobe_in      = 1'b0;
      kind_in        = KIND_STATUS;
      last_in        = 1'b1;
      zero_in        = 1'b1;
      from_rx_in     = 1'b0;
      status_in      = cmd.status;
      dumping_in     = dumping_ff;
      dump_idx_in    = dump_idx_ff;
      dump_status_in = dump_status_ff;
      if (dumping_ff) begin
         strobe_in   = 1'b1;
         kind_in     = KIND_RX;
         zero_in     = 1'b0;
         from_rx_in  = 1'b1;
         rx_re       = 1'b1;
         status_in   = dump_status_ff;
         last_in     = (dump_idx_ff == LAST_IDX);
         dump_idx_in = dump_idx_ff + 1'b1;
         if (dump_idx_ff == LAST_IDX) begin
            dumping_in = 1'b0;
         end
      end else if (pop) begin
         strobe_in = 1'b1;
         case (cmd.op)
            OP_RX_WRITE: begin
               rx_we = 1'b1;
            end
            OP_TX_WRITE: begin
               tx_we = 1'b1;
            end
            OP_TX_READ: begin
               kind_in = KIND_READ;
               zero_in = cmd.zero;
               tx_re   = 1'b1;
            end
            OP_DUMP: begin
               kind_in        = KIND_RX;
               zero_in        = 1'b0;
               from_rx_in     = 1'b1;
               rx_re          = 1'b1;
               rx_raddr       = '0;
               last_in        = (PACKET_BYTES == 1);
               dumping_in     = (PACKET_BYTES > 1);
               dump_idx_in    = IDX_W'(1);
               dump_status_in = cmd.status;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         strobe_ff  <= 1'b0;
         dumping_ff <= 1'b0;
      end else begin
         strobe_ff  <= strobe_in;
         dumping_ff <= dumping_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff        <= kind_in;
      last_ff        <= last_in;
      zero_ff        <= zero_in;
      from_rx_ff     <= from_rx_in;
      status_ff      <= status_in;
      dump_idx_ff    <= dump_idx_in;
      dump_status_ff <= dump_status_in;
   end

   always_ff @(posedge clock) begin
      if (tx_we) begin
         tx_mem[addr] <= cmd.data;
      end
      if (tx_re) begin
         tx_rd_ff <= tx_mem[addr];
      end
   end

   always_ff @(posedge clock) begin
      if (rx_we) begin
         rx_mem[addr] <= cmd.data;
      end
      if (rx_re) begin
         rx_rd_ff <= rx_mem[rx_raddr];
      end
   end

   assign rsp_strobe   = strobe_ff;
   assign rsp_kind     = kind_ff;
   assign rsp_last     = last_ff;
   assign rsp_status   = status_ff;
   assign rsp_out_byte = zero_ff ? 8'h00 : (from_rx_ff ? rx_rd_ff : tx_rd_ff);

`ifndef SYNTH
   a_dump_continues: assert property (@(posedge clock) disable iff (reset)
      (strobe_ff && (kind_ff == KIND_RX) && !last_ff)
      |=> (strobe_ff && (kind_ff == KIND_RX)))
      else $error("Packet run broke off before its last word.");

   a_single_is_last: assert property (@(posedge clock) disable iff (reset)
      (strobe_ff && (kind_ff != KIND_RX)) |-> last_ff)
      else $error("Single result not marked as last.");

   a_dump_status_stable: assert property (@(posedge clock) disable iff (reset)
      (strobe_ff && (kind_ff == KIND_RX) && !last_ff) |=> $stable(status_ff))
      else $error("Status changed in the middle of a packet run.");
`endif

endmodule

### verif/i2c_target_packet_mailbox_top_test.sv
module i2c_target_packet_mailbox_top_test;
   import i2ctpm_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int PB = PACKET_BYTES_DEFAULT;
   localparam int CYCLE_LIMIT = 200000;

   localparam logic [2:0] FUNC_SPARE_LO = 3'd6;
   localparam logic [2:0] FUNC_SPARE_HI = 3'd7;

   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] out_byte;
      logic       last;
      logic       accepted;
      logic       tx_done;
      logic       tx_pending;
      logic       rx_overrun;
      logic       rx_short;
      logic       tx_overrun;
      logic       tx_short;
   } mailbox_word_type;

   class mailbox_scoreboard_type;
      logic [7:0]       tx_bytes [PB];
      logic [7:0]       rx_bytes [PB];
      logic [6:0]       tx_length;
      logic [6:0]       load_count;
      logic [6:0]       tx_pos;
      logic [6:0]       rx_pos;
      logic             tx_armed;
      logic             reading_now;
      logic             rx_ovf;
      logic             rx_unf;
      logic             tx_ovf;
      logic             tx_unf;
      mailbox_word_type due_words [$];
      int               errors;
      int               words_checked;
      int               dumps;
      int               packets_sent;

      function new();
         foreach (tx_bytes[i]) tx_bytes[i] = '0;
         foreach (rx_bytes[i]) rx_bytes[i] = '0;
         tx_length = '0;
         load_count = '0;
         tx_pos = '0;
         rx_pos = '0;
         tx_armed = 1'b0;
         reading_now = 1'b0;
         rx_ovf = 1'b0;
         rx_unf = 1'b0;
         tx_ovf = 1'b0;
         tx_unf = 1'b0;
         errors = 0;
         words_checked = 0;
         dumps = 0;
         packets_sent = 0;
      endfunction

      function void push_word(logic [1:0] kind, logic [7:0] data, logic last,
                              logic took, logic done);
         mailbox_word_type w;
         w.kind = kind;
         w.out_byte = data;
         w.last = last;
         w.accepted = took;
         w.tx_done = done;
         w.tx_pending = tx_armed;
         w.rx_overrun = rx_ovf;
         w.rx_short = rx_unf;
         w.tx_overrun = tx_ovf;
         w.tx_short = tx_unf;
         due_words.push_back(w);
      endfunction

      function void note_event(logic [2:0] func, logic dir, logic [7:0] data);
         logic [7:0] answer;
         logic       took;
         logic       done;
         took = 1'b0;
         done = 1'b0;
         case (func)
            FUNC_ADDR_MATCH: begin
               tx_pos = '0;
               rx_pos = '0;
               reading_now = dir && tx_armed;
            end
            FUNC_WRITE_BYTE: begin
               if (rx_pos < PB) begin
                  rx_bytes[rx_pos] = data;
                  rx_pos++;
               end else begin
                  rx_ovf = 1'b1;
               end
            end
            FUNC_READ_REQ: begin
               answer = '0;
               if (reading_now && tx_pos < PB) begin
                  if (tx_pos < tx_length) answer = tx_bytes[tx_pos];
                  tx_pos++;
               end else begin
                  tx_ovf = 1'b1;
               end
               push_word(KIND_READ, answer, 1'b1, 1'b0, 1'b0);
               return;
            end
            FUNC_STOP: begin
               if (rx_pos != PB && rx_pos != 0) rx_unf = 1'b1;
               reading_now = 1'b0;
               if (tx_pos == PB) begin
                  tx_armed = 1'b0;
                  done = 1'b1;
                  packets_sent++;
               end else if (tx_pos != 0) begin
                  tx_unf = 1'b1;
               end
               if (rx_pos == PB) begin
                  dumps++;
                  for (int i = 0; i < PB; i++)
                     push_word(KIND_RX, rx_bytes[i], i == PB - 1, 1'b0, done);
                  return;
               end
            end
            FUNC_HOST_LOAD: begin
               if (!tx_armed && load_count < PB) begin
                  tx_bytes[load_count] = data;
                  load_count++;
                  took = 1'b1;
               end
            end
            FUNC_HOST_COMMIT: begin
               if (!tx_armed) begin
                  tx_length = load_count;
                  load_count = '0;
                  tx_armed = 1'b1;
                  took = 1'b1;
               end
            end
            default: ;
         endcase
         push_word(KIND_STATUS, 8'h00, 1'b1, took, done);
      endfunction

      function void check_field(string name, logic [7:0] exp_val, logic [7:0] got_val);
         if (got_val !== exp_val) begin
            $error("%s: expected %0h, got %0h", name, exp_val, got_val);
            errors++;
         end
      endfunction

      function void check_word(mailbox_word_type got);
         mailbox_word_type exp_w;
         if (due_words.size() == 0) begin
            $error("Word with no expectation waiting: kind %0d byte %0h", got.kind,
                   got.out_byte);
            errors++;
            return;
         end
         exp_w = due_words.pop_front();
         words_checked++;
         check_field("kind", 8'(exp_w.kind), 8'(got.kind));
         check_field("out_byte", exp_w.out_byte, got.out_byte);
         check_field("last", 8'(exp_w.last), 8'(got.last));
         check_field("accepted", 8'(exp_w.accepted), 8'(got.accepted));
         check_field("tx_done", 8'(exp_w.tx_done), 8'(got.tx_done));
         check_field("tx_pending", 8'(exp_w.tx_pending), 8'(got.tx_pending));
         check_field("rx_overrun", 8'(exp_w.rx_overrun), 8'(got.rx_overrun));
         check_field("rx_short", 8'(exp_w.rx_short), 8'(got.rx_short));
         check_field("tx_overrun", 8'(exp_w.tx_overrun), 8'(got.tx_overrun));
         check_field("tx_short", 8'(exp_w.tx_short), 8'(got.tx_short));
      endfunction
   endclass

   logic       clock;
   logic       reset;
   logic       start;
   logic       busy;
   logic [2:0] req_func;
   logic       req_read_dir;
   logic [7:0] req_data_byte;
   logic       rsp_strobe;
   logic [1:0] rsp_kind;
   logic [7:0] rsp_out_byte;
   logic       rsp_last;
   logic       rsp_accepted;
   logic       rsp_tx_done;
   logic       rsp_tx_pending;
   logic       rsp_rx_overrun;
   logic       rsp_rx_short;
   logic       rsp_tx_overrun;
   logic       rsp_tx_short;

   mailbox_scoreboard_type sb;
   int idle_pct;
   int events_sent;
   int cycle_count;

   i2c_target_packet_mailbox_top i_dut (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_func       (req_func),
      .req_read_dir   (req_read_dir),
      .req_data_byte  (req_data_byte),
      .rsp_strobe     (rsp_strobe),
      .rsp_kind       (rsp_kind),
      .rsp_out_byte   (rsp_out_byte),
      .rsp_last       (rsp_last),
      .rsp_accepted   (rsp_accepted),
      .rsp_tx_done    (rsp_tx_done),
      .rsp_tx_pending (rsp_tx_pending),
      .rsp_rx_overrun (rsp_rx_overrun),
      .rsp_rx_short   (rsp_rx_short),
      .rsp_tx_overrun (rsp_tx_overrun),
      .rsp_tx_short   (rsp_tx_short)
   );

   always #10 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles.", cycle_count);
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   always @(posedge clock) begin
      mailbox_word_type got;
      if (!reset && rsp_strobe) begin
         got.kind = rsp_kind;
         got.out_byte = rsp_out_byte;
         got.last = rsp_last;
         got.accepted = rsp_accepted;
         got.tx_done = rsp_tx_done;
         got.tx_pending = rsp_tx_pending;
         got.rx_overrun = rsp_rx_overrun;
         got.rx_short = rsp_rx_short;
         got.tx_overrun = rsp_tx_overrun;
         got.tx_short = rsp_tx_short;
         sb.check_word(got);
      end
   end

   task automatic send_event(input logic [2:0] func, input logic dir,
                             input logic [7:0] data);
      while ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      req_func <= func;
      req_read_dir <= dir;
      req_data_byte <= data;
      start <= 1'b1;
      do @(posedge clock); while (busy);
      sb.note_event(func, dir, data);
      events_sent++;
   endtask

   task automatic drain_words();
      start <= 1'b0;
      do @(posedge clock); while (sb.due_words.size() != 0);
   endtask

   function automatic logic [7:0] any_byte();
      return 8'($urandom_range(255));
   endfunction

   function automatic logic any_bit();
      return 1'($urandom_range(1));
   endfunction

   function automatic int transfer_length();
      int r;
      r = $urandom_range(9);
      if (r < 4) return PB;
      if (r == 4) return $urandom_range(PB + 3, PB + 1);
      return $urandom_range(PB - 1, 0);
   endfunction

   task automatic run_directed();
      send_event(FUNC_HOST_LOAD, 1'b0, 8'h00);
      send_event(FUNC_HOST_LOAD, 1'b1, 8'hFF);
      send_event(FUNC_HOST_LOAD, 1'b0, 8'hA5);
      send_event(FUNC_HOST_COMMIT, 1'b0, 8'h00);
      send_event(FUNC_HOST_COMMIT, 1'b1, 8'hFF);
      send_event(FUNC_HOST_LOAD, 1'b0, 8'h5A);
      send_event(FUNC_ADDR_MATCH, 1'b1, 8'h00);
      repeat (4) send_event(FUNC_READ_REQ, 1'b0, 8'hFF);
      send_event(FUNC_STOP, 1'b0, 8'h00);
      send_event(FUNC_STOP, 1'b1, 8'hFF);
      send_event(FUNC_ADDR_MATCH, 1'b0, 8'hFF);
      send_event(FUNC_WRITE_BYTE, 1'b0, 8'h00);
      send_event(FUNC_WRITE_BYTE, 1'b1, 8'hFF);
      send_event(FUNC_READ_REQ, 1'b0, 8'h00);
      send_event(FUNC_STOP, 1'b0, 8'h00);
      send_event(FUNC_SPARE_LO, 1'b1, 8'hFF);
      send_event(FUNC_SPARE_HI, 1'b0, 8'h00);
      send_event(FUNC_STOP, 1'b0, 8'h00);
   endtask

   task automatic run_random(input int quota);
      int first;
      int n;
      first = events_sent;
      while (events_sent - first < quota) begin
         case ($urandom_range(9))
            0, 1, 2: begin
               n = transfer_length();
               send_event(FUNC_ADDR_MATCH, 1'b0, any_byte());
               repeat (n) send_event(FUNC_WRITE_BYTE, any_bit(), any_byte());
               send_event(FUNC_STOP, any_bit(), any_byte());
               if ($urandom_range(3) == 0) send_event(FUNC_STOP, any_bit(), any_byte());
            end
            3, 4: begin
               n = ($urandom_range(4) == 0) ? $urandom_range(PB + 2, PB - 4)
                                            : $urandom_range(8);
               repeat (n) send_event(FUNC_HOST_LOAD, any_bit(), any_byte());
               if ($urandom_range(4) != 0)
                  send_event(FUNC_HOST_COMMIT, any_bit(), any_byte());
            end
            5, 6, 7: begin
               n = transfer_length();
               send_event(FUNC_ADDR_MATCH, 1'b1, any_byte());
               repeat (n) send_event(FUNC_READ_REQ, any_bit(), any_byte());
               send_event(FUNC_STOP, any_bit(), any_byte());
               if ($urandom_range(3) == 0) send_event(FUNC_STOP, any_bit(), any_byte());
            end
            default: begin
               repeat ($urandom_range(3, 1))
                  send_event(3'($urandom_range(7)), any_bit(), any_byte());
            end
         endcase
      end
   endtask

   initial begin
      clock = 1'b0;
      reset = 1'b1;
      start = 1'b0;
      req_func = FUNC_ADDR_MATCH;
      req_read_dir = 1'b0;
      req_data_byte = 8'h00;
      idle_pct = 0;
      events_sent = 0;
      sb = new();
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      idle_pct = 26;
      run_directed();
      drain_words();
      run_random(80);
      drain_words();
      idle_pct = 45;
      run_random(80);
      drain_words();
      idle_pct = 0;
      run_random(80);
      drain_words();
      repeat (10) @(posedge clock);

      $display("Sent %0d events and checked %0d words.", events_sent, sb.words_checked);
      $display("Saw %0d receive packet dumps and %0d completed transmit packets.",
               sb.dumps, sb.packets_sent);
      if (sb.errors == 0 && sb.due_words.size() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("%0d mismatches, %0d words still expected.", sb.errors,
                  sb.due_words.size());
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

### files.f
hw/rtl/i2ctpm_pkg.sv
hw/rtl/i2ctpm_front.sv
hw/rtl/i2ctpm_cmd_queue.sv
hw/rtl/i2ctpm_back.sv
hw/rtl/i2c_target_packet_mailbox_top.sv
verif/i2c_target_packet_mailbox_top_test.sv
